>>> rtl/org_pkg.sv
// Package with the shared types, widths and codes of the obstacle repulsion gradient block.
`timescale 1ns / 1ps

package org_pkg;

    // Table size and derived index widths.
    localparam int MAX_OBSTACLES = 64;
    localparam int IDX_W         = $clog2(MAX_OBSTACLES);
    localparam int CNT_W         = IDX_W + 1;

    // Arithmetic widths.
    localparam int POS_W      = 32;
    localparam int RAD_W      = 26;
    localparam int DIFF_W     = POS_W + 1;
    localparam int SQ_W       = 2 * RAD_W;
    localparam int DSQ_W      = SQ_W + 2;
    localparam int ROOT_STEPS = RAD_W;
    localparam int ROOT_REM_W = RAD_W + 4;
    localparam int PROD_W     = 2 * RAD_W + 1;
    localparam int DIV_STEPS  = PROD_W;
    localparam int ACC_W      = PROD_W + IDX_W + 2;
    localparam int STEP_W     = $clog2(DIV_STEPS);
    localparam int ENTRY_W    = 3 * POS_W;

    localparam logic [RAD_W-1:0] RADIUS_RESET = 26'd655360;

    // Command codes.
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef struct packed {
        logic [1:0]              command;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } req_t;

    typedef struct packed {
        logic signed [POS_W-1:0] grad_x;
        logic signed [POS_W-1:0] grad_y;
        logic signed [POS_W-1:0] grad_z;
        logic [1:0]              status;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;
        logic             wr_en;
        logic [IDX_W-1:0] addr;
        logic             rd_en;
        logic             diff_en;
        logic             sq_en;
        logic             root_load;
        logic             root_step;
        logic             mul_en;
        logic             div_load;
        logic             div_step;
        logic             acc_clr;
        logic             acc_en;
        logic             out_en;
        logic             query;
        logic             full;
    } dp_ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic skip;
    } dp_stat_t;

endpackage

>>> rtl/org_datapath.sv
// Datapath: obstacle memory, radius register, square root, dividers and accumulators.
`timescale 1ns / 1ps

module org_datapath import org_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [RAD_W-1:0] cfg_data,
    input  req_t             request,
    input  dp_ctrl_t         ctrl,
    output dp_stat_t         stat,
    output rsp_t             result,
    output logic             result_valid
);

    logic [RAD_W-1:0]        radius_reg;
    logic [ENTRY_W-1:0]      mem [MAX_OBSTACLES];
    logic [ENTRY_W-1:0]      rd_reg;
    logic signed [POS_W-1:0] pt_reg [3];
    logic                    sign_reg [3];
    logic [RAD_W-1:0]        mag_reg [3];
    logic                    far_reg;
    logic [SQ_W-1:0]         sq_reg [3];
    logic [SQ_W-1:0]         rsq_reg;
    logic [SQ_W-1:0]         rad_reg;
    logic [RAD_W-1:0]        root_reg;
    logic [ROOT_REM_W-1:0]   rem_reg;
    logic [PROD_W-1:0]       prod_reg [3];
    logic [PROD_W-1:0]       num_reg [3];
    logic [RAD_W-1:0]        drem_reg [3];
    logic signed [ACC_W-1:0] acc_reg [3];
    rsp_t                    result_reg;
    logic                    valid_reg;

    logic signed [POS_W-1:0]  obs [3];
    logic signed [DIFF_W-1:0] diff [3];
    logic [DIFF_W-1:0]        absv [3];
    logic                     far_next;
    logic [DSQ_W-1:0]         dsq;
    logic [ROOT_REM_W-1:0]    rem_sh;
    logic [ROOT_REM_W-1:0]    trial;
    logic [RAD_W-1:0]         gap;
    logic [RAD_W:0]           drem_sh [3];
    logic [POS_W-1:0]         grad [3];
    logic                     sat_hi [3];
    logic                     sat_lo [3];
    logic                     any_sat;

    // Radius register, written through the configuration channel.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_we)
        begin
            radius_reg <= cfg_data;
        end
    end

    // Obstacle memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            mem[ctrl.addr] <= {request.pos_x, request.pos_y, request.pos_z};
        end
        if (ctrl.rd_en)
        begin
            rd_reg <= mem[ctrl.addr];
        end
    end

    // Differences to the query point and the out-of-box test.
    always_comb
    begin
        obs[0]   = rd_reg[3*POS_W-1:2*POS_W];
        obs[1]   = rd_reg[2*POS_W-1:POS_W];
        obs[2]   = rd_reg[POS_W-1:0];
        far_next = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = DIFF_W'(pt_reg[i]) - DIFF_W'(obs[i]);
            absv[i] = diff[i][DIFF_W-1] ? DIFF_W'(-diff[i]) : DIFF_W'(diff[i]);
            if (absv[i] > {{(DIFF_W-RAD_W){1'b0}}, radius_reg})
            begin
                far_next = 1'b1;
            end
        end
    end

    // Squared distance and the skip decision.
    always_comb
    begin
        dsq = DSQ_W'(sq_reg[0]) + DSQ_W'(sq_reg[1]) + DSQ_W'(sq_reg[2]);
        stat.skip = far_reg || (dsq == '0) || (dsq > DSQ_W'(rsq_reg));
    end

    // One root digit per step: bring down two radicand bits and try the next bit.
    always_comb
    begin
        rem_sh = {rem_reg[ROOT_REM_W-3:0], rad_reg[SQ_W-1:SQ_W-2]};
        trial  = {{(ROOT_REM_W-RAD_W-2){1'b0}}, root_reg, 2'b01};
        gap    = radius_reg - root_reg;
        for (int i = 0; i < 3; i++)
        begin
            drem_sh[i] = {drem_reg[i], num_reg[i][PROD_W-1]};
        end
    end

    // Iterative units and the per-obstacle pipeline registers.
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            pt_reg[0] <= request.pos_x;
            pt_reg[1] <= request.pos_y;
            pt_reg[2] <= request.pos_z;
        end
        if (ctrl.diff_en)
        begin
            far_reg <= far_next;
            for (int i = 0; i < 3; i++)
            begin
                sign_reg[i] <= diff[i][DIFF_W-1];
                mag_reg[i]  <= absv[i][RAD_W-1:0];
            end
        end
        if (ctrl.sq_en)
        begin
            rsq_reg <= SQ_W'(radius_reg) * SQ_W'(radius_reg);
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i] <= SQ_W'(mag_reg[i]) * SQ_W'(mag_reg[i]);
            end
        end
        if (ctrl.root_load)
        begin
            rad_reg  <= dsq[SQ_W-1:0];
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (ctrl.root_step)
        begin
            rad_reg <= {rad_reg[SQ_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[RAD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[RAD_W-2:0], 1'b0};
            end
        end
        if (ctrl.mul_en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= {SQ_W'(mag_reg[i]) * SQ_W'(gap), 1'b0};
            end
        end
        // Three restoring dividers share the root as divisor, one quotient bit a step.
        for (int i = 0; i < 3; i++)
        begin
            if (ctrl.div_load)
            begin
                num_reg[i]  <= prod_reg[i];
                drem_reg[i] <= '0;
            end
            else if (ctrl.div_step)
            begin
                if (drem_sh[i] >= {1'b0, root_reg})
                begin
                    drem_reg[i] <= RAD_W'(drem_sh[i] - {1'b0, root_reg});
                    num_reg[i]  <= {num_reg[i][PROD_W-2:0], 1'b1};
                end
                else
                begin
                    drem_reg[i] <= drem_sh[i][RAD_W-1:0];
                    num_reg[i]  <= {num_reg[i][PROD_W-2:0], 1'b0};
                end
            end
        end
        // Signed accumulation of the quotients.
        for (int i = 0; i < 3; i++)
        begin
            if (ctrl.acc_clr)
            begin
                acc_reg[i] <= '0;
            end
            else if (ctrl.acc_en)
            begin
                if (sign_reg[i])
                begin
                    acc_reg[i] <= acc_reg[i] - ACC_W'(num_reg[i]);
                end
                else
                begin
                    acc_reg[i] <= acc_reg[i] + ACC_W'(num_reg[i]);
                end
            end
        end
    end

    // Clamp the sums to 32 bits.
    always_comb
    begin
        any_sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            sat_hi[i] = !acc_reg[i][ACC_W-1] && (|acc_reg[i][ACC_W-2:POS_W-1]);
            sat_lo[i] = acc_reg[i][ACC_W-1] && !(&acc_reg[i][ACC_W-2:POS_W-1]);
            if (sat_hi[i])
            begin
                grad[i] = {1'b0, {(POS_W-1){1'b1}}};
            end
            else if (sat_lo[i])
            begin
                grad[i] = {1'b1, {(POS_W-1){1'b0}}};
            end
            else
            begin
                grad[i] = acc_reg[i][POS_W-1:0];
            end
            any_sat = any_sat | sat_hi[i] | sat_lo[i];
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (ctrl.out_en)
        begin
            if (ctrl.query)
            begin
                result_reg.grad_x <= grad[0];
                result_reg.grad_y <= grad[1];
                result_reg.grad_z <= grad[2];
                result_reg.status <= any_sat ? ST_SAT : ST_OK;
            end
            else
            begin
                result_reg.grad_x <= '0;
                result_reg.grad_y <= '0;
                result_reg.grad_z <= '0;
                result_reg.status <= ctrl.full ? ST_FULL : ST_OK;
            end
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= ctrl.out_en;
        end
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule

>>> rtl/org_ctrl.sv
// Controller: command decode, obstacle count and the per-obstacle sequencer.
`timescale 1ns / 1ps

module org_ctrl import org_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  req_t     request,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl,
    output logic     busy
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_DIFF = 4'd2;
    localparam logic [3:0] S_SQ   = 4'd3;
    localparam logic [3:0] S_CHK  = 4'd4;
    localparam logic [3:0] S_ROOT = 4'd5;
    localparam logic [3:0] S_MUL  = 4'd6;
    localparam logic [3:0] S_DIVL = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_ACC  = 4'd9;
    localparam logic [3:0] S_NEXT = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              query_reg, query_next;
    logic              full_reg, full_next;
    logic              accept;
    logic              table_full;

    assign accept     = start && (state_reg == S_IDLE);
    assign table_full = (count_reg == CNT_W'(MAX_OBSTACLES));

    // Next state and datapath commands.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        query_next = query_reg;
        full_next  = full_reg;
        ctrl       = '0;
        ctrl.addr  = idx_reg;
        ctrl.query = query_reg;
        ctrl.full  = full_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load    = 1'b1;
                    ctrl.acc_clr = 1'b1;
                    query_next   = 1'b0;
                    full_next    = 1'b0;
                    idx_next     = '0;
                    state_next   = S_FIN;
                    if (request.command == CMD_CLEAR)
                    begin
                        count_next = '0;
                    end
                    else if (request.command == CMD_APPEND)
                    begin
                        if (table_full)
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            ctrl.wr_en = 1'b1;
                            ctrl.addr  = count_reg[IDX_W-1:0];
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (request.command == CMD_QUERY)
                    begin
                        query_next = 1'b1;
                        if (count_reg != '0)
                        begin
                            state_next = S_RD;
                        end
                    end
                end
            end
            S_RD:
            begin
                ctrl.rd_en = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                ctrl.diff_en = 1'b1;
                state_next   = S_SQ;
            end
            S_SQ:
            begin
                ctrl.sq_en = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                step_next = '0;
                if (stat.skip)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    ctrl.root_load = 1'b1;
                    state_next     = S_ROOT;
                end
            end
            S_ROOT:
            begin
                ctrl.root_step = 1'b1;
                step_next      = step_reg + 1'b1;
                if (step_reg == STEP_W'(ROOT_STEPS - 1))
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                ctrl.mul_en = 1'b1;
                state_next  = S_DIVL;
            end
            S_DIVL:
            begin
                ctrl.div_load = 1'b1;
                step_next     = '0;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                ctrl.div_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                ctrl.acc_en = 1'b1;
                state_next  = S_NEXT;
            end
            S_NEXT:
            begin
                if ({1'b0, idx_reg} == count_reg - 1'b1)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD;
                end
            end
            S_FIN:
            begin
                ctrl.out_en = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            step_reg  <= '0;
            query_reg <= 1'b0;
            full_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            query_reg <= query_next;
            full_reg  <= full_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

>>> rtl/obstacle_repulsion_gradient.sv
// Top level of the obstacle repulsion gradient block.
//
// Usage: a command is transferred when start is high and busy is low. The
// request struct carries the command (clear, append, query) and a position.
// Every command gives exactly one result, shown on result for one cycle while
// result_valid is high; the receiver cannot stall and must take it then.
// Clear and append go straight to the finish state and the result strobe.
// A query walks the stored obstacles one at a time. An obstacle outside the
// influence radius, or at the query point itself, is skipped after the check
// state; one inside passes through the 26-step square root and the 53-step
// dividers that produce one bit per cycle, then the accumulators; the next
// command can follow the result strobe.
// The radius register is written over cfg_valid/cfg_ready; ready is high
// only while the block is idle. Reset empties the obstacle table and loads
// the radius with 10 m; no result is pending after reset.
`timescale 1ns / 1ps

module obstacle_repulsion_gradient import org_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  req_t             request,
    output logic             result_valid,
    output rsp_t             result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [RAD_W-1:0] cfg_data
);

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    // Configuration transfers are taken while idle.
    assign cfg_ready = !busy;

    org_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .stat    (stat),
        .ctrl    (ctrl),
        .busy    (busy)
    );

    org_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .request      (request),
        .ctrl         (ctrl),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule

>>> rtl/org_checker.sv
// Port-level checker for the obstacle repulsion gradient block, with its bind.
`timescale 1ns / 1ps

module org_checker import org_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input req_t             request,
    input logic             result_valid,
    input rsp_t             result,
    input logic             cfg_valid,
    input logic             cfg_ready
);

    // A result strobe lasts a single cycle.
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for more than one cycle");

    // A transfer makes the block busy.
    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after a command transfer");

    // Non-query commands answer straight through the finish state, with no table walk.
    a_short_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.command != CMD_QUERY) |-> ##2 result_valid)
        else $error("clear or append result missing");

    // A dropped append reports a zero gradient.
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.status == ST_FULL) |->
        (result.grad_x == '0 && result.grad_y == '0 && result.grad_z == '0))
        else $error("dropped append with a nonzero gradient");

    // Configuration is never taken while a command is in progress.
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |-> !busy)
        else $error("configuration transfer while busy");

endmodule

bind obstacle_repulsion_gradient org_checker u_org_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready)
);
